[rtl/core/pfp_pkg.sv]
// Shared types and constants for the pose frame parser.
// Used by pfp_front, pfp_fifo, pfp_back and pose_frame_parser.
`default_nettype none

package pfp_pkg;

  // Event counter width (wraps at 2**COUNTER_BITS)
  localparam int COUNTER_BITS = 32;

  // Frame format
  localparam logic [7:0] HDR_FIRST  = 8'h0F;
  localparam logic [7:0] HDR_SECOND = 8'hF0;
  localparam int         FRAME_LEN  = 10;

  // Frame position codes
  localparam logic [3:0] POS_SEARCH = 4'd0;
  localparam logic [3:0] POS_HDR2   = 4'd1;
  localparam logic [3:0] POS_CSUM   = 4'(FRAME_LEN - 1);

  // Frame queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Yaw: mrad -> centideg is 18/pi, in Q16
  localparam logic signed [19:0] YAW_Q16   = 20'sd375494;
  localparam logic signed [35:0] YAW_ROUND = 36'sd32768;

  // Wrap into (-18000, 18000]: bias by (half turn - 1) plus six turns so
  // the value is non-negative, reduce mod one turn, remove the half bias.
  localparam int HALF_BIAS = 17999;
  localparam int FULL_TURN = 36000;
  localparam logic [21:0] WRAP_BIAS = 22'(HALF_BIAS + 6 * FULL_TURN);
  localparam logic [18:0] TURN_X8   = 19'(8 * FULL_TURN);
  localparam logic [18:0] TURN_X4   = 19'(4 * FULL_TURN);
  localparam logic [18:0] TURN_X2   = 19'(2 * FULL_TURN);
  localparam logic [18:0] TURN_X1   = 19'(FULL_TURN);
  localparam logic [15:0] HALF_BIAS16 = 16'(HALF_BIAS);

  // One completed frame, as handed from front to back
  typedef struct packed {
    logic                    good;
    logic [15:0]             x_word;
    logic [15:0]             y_word;
    logic [15:0]             yaw_word;
    logic [COUNTER_BITS-1:0] hdr_cnt;
    logic [COUNTER_BITS-1:0] byte_cnt;
  } frame_rec_t;

endpackage

`default_nettype wire

[rtl/core/pose_frame_parser.sv]
// Pose frame parser: front end, frame queue and back end.
// Depends on pfp_pkg, pfp_front, pfp_fifo and pfp_back.
//
// Takes one serial byte per cycle and finds 10-byte frames that open with
// 0x0F 0xF0 and close with an 8-bit sum checksum over bytes 0-8. Each
// completed frame yields one result: frame_good, the last good raw words,
// the pose in mm (x = -raw y, y = raw x), the yaw in centidegrees plus the
// configured offset wrapped into (-18000, 18000], and four wrapping event
// counters. Bytes that do not complete a frame produce no result. A result
// passes from its checksum byte through the queue, the multiply, two
// reduction stages and the output register, and the three-stage yaw
// pipeline plus a two-entry frame queue let input run on while a result waits.
// The input stalls only on a checksum byte when the frame queue is full.
// The offset register is written through cfg_valid (always ready).
`default_nettype none

module pose_frame_parser
  import pfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [15:0] yaw_offset_centideg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    frame_good,
  output logic signed [15:0]      raw_x,
  output logic signed [15:0]      raw_y,
  output logic signed [15:0]      raw_yaw,
  output logic signed [16:0]      x_mm,
  output logic signed [15:0]      y_mm,
  output logic signed [15:0]      yaw_centideg,
  output logic [31:0]             good_frames,
  output logic [31:0]             checksum_errors,
  output logic [31:0]             header_errors,
  output logic [31:0]             bytes_seen
);

  frame_rec_t push_rec, head_rec;
  logic       q_push, q_full, q_pop, q_not_empty;

  pfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  pfp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  pfp_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .yaw_offset_centideg (yaw_offset_centideg),
    .q_not_empty         (q_not_empty),
    .q_rec               (head_rec),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .frame_good          (frame_good),
    .raw_x               (raw_x),
    .raw_y               (raw_y),
    .raw_yaw             (raw_yaw),
    .x_mm                (x_mm),
    .y_mm                (y_mm),
    .yaw_centideg        (yaw_centideg),
    .good_frames         (good_frames),
    .checksum_errors     (checksum_errors),
    .header_errors       (header_errors),
    .bytes_seen          (bytes_seen)
  );

endmodule

`default_nettype wire

[rtl/core/pfp_front.sv]
// Front end: header sync, running checksum, payload capture, byte and
// header error counts. Emits one frame record per completed frame. Uses pfp_pkg.
`default_nettype none

module pfp_front
  import pfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output frame_rec_t      q_rec
);

  logic [3:0]              pos, pos_next;
  logic [7:0]              sum, sum_next;
  logic [47:0]             payload, payload_next;
  logic [COUNTER_BITS-1:0] hdr_cnt, hdr_cnt_next;
  logic [COUNTER_BITS-1:0] byte_cnt, byte_cnt_next;
  logic                    accept;

  // Only the checksum byte needs queue space
  assign in_stall = (pos >= POS_CSUM) && q_full;
  assign accept   = in_valid && !in_stall;

  // Per-byte parse
  always_comb begin
    pos_next      = pos;
    sum_next      = sum;
    payload_next  = payload;
    hdr_cnt_next  = hdr_cnt;
    byte_cnt_next = byte_cnt;
    q_push        = 1'b0;
    if (accept) begin
      byte_cnt_next = byte_cnt + 1'b1;
      priority if (pos == POS_SEARCH) begin
        if (rx_byte == HDR_FIRST) begin
          sum_next = rx_byte;
          pos_next = POS_HDR2;
        end
      end else if (pos == POS_HDR2) begin
        if (rx_byte == HDR_SECOND) begin
          sum_next = sum + rx_byte;
          pos_next = pos + 1'b1;
        end else begin
          // resync: a repeated first header byte restarts the frame
          hdr_cnt_next = hdr_cnt + 1'b1;
          sum_next     = rx_byte;
          pos_next     = (rx_byte == HDR_FIRST) ? POS_HDR2 : POS_SEARCH;
        end
      end else if (pos < POS_CSUM) begin
        // bytes 2..8; the last six shifted in are the three words
        sum_next     = sum + rx_byte;
        payload_next = {payload[39:0], rx_byte};
        pos_next     = pos + 1'b1;
      end else begin
        q_push   = 1'b1;
        pos_next = POS_SEARCH;
      end
    end
  end

  // Record for the back end
  always_comb begin
    q_rec.good     = (sum == rx_byte);
    q_rec.x_word   = payload[47:32];
    q_rec.y_word   = payload[31:16];
    q_rec.yaw_word = payload[15:0];
    q_rec.hdr_cnt  = hdr_cnt;
    q_rec.byte_cnt = byte_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_SEARCH;
      sum      <= '0;
      hdr_cnt  <= '0;
      byte_cnt <= '0;
    end else begin
      pos      <= pos_next;
      sum      <= sum_next;
      hdr_cnt  <= hdr_cnt_next;
      byte_cnt <= byte_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    payload <= payload_next;
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_CSUM)
    else $error("frame position out of range");
  a_csum_ends: assert property (@(posedge clk) disable iff (rst)
    accept && (pos == POS_CSUM) |=> pos == POS_SEARCH)
    else $error("frame did not end after checksum byte");
  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("frame pushed into full queue");
`endif

endmodule

`default_nettype wire

[rtl/core/pfp_fifo.sv]
// Short frame queue decoupling the byte parser from the pose back end.
// Uses pfp_pkg for the record type and depth.
`default_nettype none

module pfp_fifo
  import pfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire frame_rec_t  push_rec,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output frame_rec_t       head_rec
);

  frame_rec_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_rec  = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");
`endif

endmodule

`default_nettype wire

[rtl/core/pfp_back.sv]
// Back end: yaw conversion pipeline, pose and frame counters, output register
// and the yaw offset register. Uses pfp_pkg.
`default_nettype none

module pfp_back
  import pfp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // offset register write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [15:0] yaw_offset_centideg,
  // frame queue head
  input  wire logic               q_not_empty,
  input  wire frame_rec_t         q_rec,
  output logic                    q_pop,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    frame_good,
  output logic signed [15:0]      raw_x,
  output logic signed [15:0]      raw_y,
  output logic signed [15:0]      raw_yaw,
  output logic signed [16:0]      x_mm,
  output logic signed [15:0]      y_mm,
  output logic signed [15:0]      yaw_centideg,
  output logic [31:0]             good_frames,
  output logic [31:0]             checksum_errors,
  output logic [31:0]             header_errors,
  output logic [31:0]             bytes_seen
);

  logic signed [15:0]      offset;
  logic                    adv;
  logic                    s1_valid, s2_valid, s3_valid;
  frame_rec_t              s1_rec, s2_rec, s3_rec;
  logic signed [35:0]      s1_prod;
  logic [18:0]             s2_rem, s3_rem;
  logic [15:0]             s3_yaw;
  logic signed [35:0]      rounded;
  logic [21:0]             biased;
  logic [18:0]             r8, r4, r2, r1;
  logic [15:0]             pose_x, pose_y, pose_yaw, yaw_res;
  logic [15:0]             pose_x_next, pose_y_next, pose_yaw_next, yaw_res_next;
  logic [COUNTER_BITS-1:0] good_cnt, csum_cnt, good_cnt_next, csum_cnt_next;
  logic                    load;

  assign cfg_ready = 1'b1;

  // Offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_valid) begin
      offset <= yaw_offset_centideg;
    end
  end

  // Whole pipeline moves while the output register can take a result
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv;
  assign load  = adv && s3_valid;

  // Stage 2 math: round, add offset and bias, first two reduction steps
  always_comb begin
    rounded = (s1_prod + YAW_ROUND) >>> 16;
    biased  = {{2{rounded[19]}}, rounded[19:0]} + {{6{offset[15]}}, offset} + WRAP_BIAS;
    r8      = (biased[18:0] >= TURN_X8) ? biased[18:0] - TURN_X8 : biased[18:0];
    r4      = (r8 >= TURN_X4) ? r8 - TURN_X4 : r8;
  end

  // Stage 3 math: last two reduction steps, remove half-turn bias
  always_comb begin
    r2 = (s2_rem >= TURN_X2) ? s2_rem - TURN_X2 : s2_rem;
    r1 = (r2 >= TURN_X1) ? r2 - TURN_X1 : r2;
  end
  assign s3_rem = r1;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_not_empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rec  <= q_rec;
      s1_prod <= $signed(q_rec.yaw_word) * YAW_Q16;
      s2_rec  <= s1_rec;
      s2_rem  <= r4;
      s3_rec  <= s2_rec;
      s3_yaw  <= s3_rem[15:0] - HALF_BIAS16;
    end
  end

  // Pose and frame counters update on the frame reaching the output
  always_comb begin
    pose_x_next   = pose_x;
    pose_y_next   = pose_y;
    pose_yaw_next = pose_yaw;
    yaw_res_next  = yaw_res;
    good_cnt_next = good_cnt;
    csum_cnt_next = csum_cnt;
    if (load) begin
      if (s3_rec.good) begin
        pose_x_next   = s3_rec.x_word;
        pose_y_next   = s3_rec.y_word;
        pose_yaw_next = s3_rec.yaw_word;
        yaw_res_next  = s3_yaw;
        good_cnt_next = good_cnt + 1'b1;
      end else begin
        csum_cnt_next = csum_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x   <= '0;
      pose_y   <= '0;
      pose_yaw <= '0;
      yaw_res  <= '0;
      good_cnt <= '0;
      csum_cnt <= '0;
    end else begin
      pose_x   <= pose_x_next;
      pose_y   <= pose_y_next;
      pose_yaw <= pose_yaw_next;
      yaw_res  <= yaw_res_next;
      good_cnt <= good_cnt_next;
      csum_cnt <= csum_cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      frame_good      <= s3_rec.good;
      raw_x           <= pose_x_next;
      raw_y           <= pose_y_next;
      raw_yaw         <= pose_yaw_next;
      x_mm            <= 17'sd0 - {pose_y_next[15], pose_y_next};
      y_mm            <= pose_x_next;
      yaw_centideg    <= yaw_res_next;
      good_frames     <= 32'(good_cnt_next);
      checksum_errors <= 32'(csum_cnt_next);
      header_errors   <= 32'(s3_rec.hdr_cnt);
      bytes_seen      <= 32'(s3_rec.byte_cnt);
    end
  end

`ifndef SYNTH
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ($signed(s3_yaw) >= -16'sd17999) && ($signed(s3_yaw) <= 16'sd18000))
    else $error("wrapped yaw out of range");
  a_good_count: assert property (@(posedge clk) disable iff (rst)
    load && s3_rec.good |=> good_cnt == $past(good_cnt) + 1'b1)
    else $error("good frame not counted");
  a_bad_keeps_pose: assert property (@(posedge clk) disable iff (rst)
    load && !s3_rec.good |=> $stable(pose_x) && $stable(pose_y) && $stable(yaw_res))
    else $error("pose changed on checksum failure");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s3_valid) && (!s3_valid || $stable(s3_yaw)))
    else $error("pipeline moved while output blocked");
`endif

endmodule

`default_nettype wire
